>>> rtl/ntl_pkg.sv
// ----------------------------------------------------------------------------
// ntl_pkg
// Shared types, character codes and helper functions for the netlist lexer.
// ----------------------------------------------------------------------------
package ntl_pkg;

	localparam int FIFO_DEPTH = 8;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int MAX_RES    = 3;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LBRK   = 8'h5B;
	localparam logic [7:0] CH_RBRK   = 8'h5D;
	localparam logic [7:0] CH_TILDE  = 8'h7E;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_L      = 8'h6C;

	localparam logic [2:0] TT_STRING = 3'd0;
	localparam logic [2:0] TT_NULL   = 3'd1;
	localparam logic [2:0] TT_LBRK   = 3'd2;
	localparam logic [2:0] TT_RBRK   = 3'd3;
	localparam logic [2:0] TT_LT     = 3'd4;
	localparam logic [2:0] TT_GT     = 3'd5;
	localparam logic [2:0] TT_PCT    = 3'd6;
	localparam logic [2:0] TT_TILDE  = 3'd7;

	// null matcher: 0..4 characters matched, NM_FAIL on mismatch
	localparam logic [2:0] NM_ZERO   = 3'd0;
	localparam logic [2:0] NM_FULL   = 3'd4;
	localparam logic [2:0] NM_FAIL   = 3'd5;

	typedef struct packed {
		logic       has_char;
		logic [7:0] token_char;
		logic       token_end;
		logic [2:0] token_type;
		logic       line_done;
		logic       run_last;
	} res_t;

	function automatic logic is_sep(input logic [7:0] c);
		case (c)
			CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR,
			CH_EQ, CH_LPAR, CH_RPAR, CH_COMMA: is_sep = 1'b1;
			default:                            is_sep = 1'b0;
		endcase
	endfunction

	function automatic logic [2:0] single_type(input logic [7:0] c);
		unique case (c)
			CH_LBRK:  single_type = TT_LBRK;
			CH_RBRK:  single_type = TT_RBRK;
			CH_LT:    single_type = TT_LT;
			CH_GT:    single_type = TT_GT;
			CH_PCT:   single_type = TT_PCT;
			CH_TILDE: single_type = TT_TILDE;
			default:  single_type = TT_STRING;
		endcase
	endfunction

	function automatic logic [7:0] null_char(input logic [1:0] idx);
		unique case (idx)
			2'd0:    null_char = CH_N;
			2'd1:    null_char = CH_U;
			default: null_char = CH_L;
		endcase
	endfunction

	function automatic logic [2:0] track_null(input logic [2:0] nm, input logic [7:0] c);
		if (nm < NM_FULL && c == null_char(nm[1:0]))
			track_null = nm + 3'd1;
		else
			track_null = NM_FAIL;
	endfunction

endpackage

>>> rtl/netlist_token_lexer.sv
// ----------------------------------------------------------------------------
// netlist_token_lexer
// Splits a text line, one byte per request, into token characters, typed
// token end markers and a line-done marker.
// ----------------------------------------------------------------------------
// Path: a byte's results pass through the input register, then the queue, to the outputs.
// Throughput: one byte per cycle while each byte yields at most one result
// and no result stalls; the output drains one result per cycle.
// A byte is lexed combinationally from the input register into an 8-entry queue.
// Reset: arst_n clears lexer state, the input valid bit and the queue pointers and count.
module netlist_token_lexer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_line,
	output logic       result_valid,
	input  logic       result_ready,
	output logic       has_char,
	output logic [7:0] token_char,
	output logic       token_end,
	output logic [2:0] token_type,
	output logic       line_done,
	output logic       run_last
);
	import ntl_pkg::*;

	typedef enum logic [1:0] {
		M_IDLE,
		M_WORD,
		M_QEMPTY,
		M_QCHARS
	} mode_t;

	mode_t            mode_q, mode_d;
	logic [2:0]       nm_q, nm_d;
	logic [2:0]       ft_q, ft_d;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             eol_s1;

	res_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	res_t             res [MAX_RES];
	logic [1:0]       n;
	logic             push, pop;
	logic [2:0]       st;
	logic             eol;

	function automatic logic [2:0] close_type(input mode_t m, input logic [2:0] nm,
		input logic [2:0] ft);
		if (m == M_QCHARS && ft != TT_STRING)
			close_type = ft;
		else if (nm == NM_FULL)
			close_type = TT_NULL;
		else
			close_type = TT_STRING;
	endfunction

	// lexing of the registered byte
	always_comb begin
		mode_d = mode_q;
		nm_d   = nm_q;
		ft_d   = ft_q;
		n      = 2'd0;
		for (int i = 0; i < MAX_RES; i++)
			res[i] = '0;
		st  = single_type(byte_s1);
		eol = eol_s1 || (byte_s1 == CH_NUL);

		if (byte_s1 != CH_NUL) begin
			unique case (mode_q)
				M_IDLE: begin
					if (st != TT_STRING) begin
						res[n] = '{1'b1, byte_s1, 1'b1, st, 1'b0, 1'b0};
						n      = n + 2'd1;
					end else if (byte_s1 == CH_QUOTE) begin
						mode_d = M_QEMPTY;
						nm_d   = NM_ZERO;
						ft_d   = TT_STRING;
					end else if (!is_sep(byte_s1)) begin
						mode_d = M_WORD;
						ft_d   = TT_STRING;
						nm_d   = track_null(NM_ZERO, byte_s1);
						res[n] = '{1'b1, byte_s1, 1'b0, TT_STRING, 1'b0, 1'b0};
						n      = n + 2'd1;
					end
				end
				M_WORD: begin
					if (is_sep(byte_s1) || st != TT_STRING) begin
						res[n] = '{1'b0, CH_NUL, 1'b1, close_type(mode_q, nm_q, ft_q),
							1'b0, 1'b0};
						n      = n + 2'd1;
						mode_d = M_IDLE;
						nm_d   = NM_ZERO;
						ft_d   = TT_STRING;
						if (st != TT_STRING) begin
							res[n] = '{1'b1, byte_s1, 1'b1, st, 1'b0, 1'b0};
							n      = n + 2'd1;
						end
					end else begin
						nm_d   = track_null(nm_q, byte_s1);
						res[n] = '{1'b1, byte_s1, 1'b0, TT_STRING, 1'b0, 1'b0};
						n      = n + 2'd1;
					end
				end
				default: begin
					if (byte_s1 == CH_QUOTE) begin
						res[n] = '{1'b0, CH_NUL, 1'b1, close_type(mode_q, nm_q, ft_q),
							1'b0, 1'b0};
						n      = n + 2'd1;
						mode_d = M_IDLE;
						nm_d   = NM_ZERO;
						ft_d   = TT_STRING;
					end else begin
						if (mode_q == M_QEMPTY) begin
							ft_d   = st;
							mode_d = M_QCHARS;
						end
						nm_d   = track_null(nm_q, byte_s1);
						res[n] = '{1'b1, byte_s1, 1'b0, TT_STRING, 1'b0, 1'b0};
						n      = n + 2'd1;
					end
				end
			endcase
		end

		if (eol) begin
			if (mode_d != M_IDLE) begin
				res[n] = '{1'b0, CH_NUL, 1'b1, close_type(mode_d, nm_d, ft_d), 1'b0, 1'b0};
				n      = n + 2'd1;
			end
			res[n] = '{1'b0, CH_NUL, 1'b0, TT_STRING, 1'b1, 1'b0};
			n      = n + 2'd1;
			mode_d = M_IDLE;
			nm_d   = NM_ZERO;
			ft_d   = TT_STRING;
		end

		if (n != 2'd0)
			res[n - 2'd1].run_last = 1'b1;
	end

	// lex only when the queue has room for a full group
	assign push       = valid_s1 && (count_q <= CNT_W'(FIFO_DEPTH - MAX_RES));
	assign byte_ready = !valid_s1 || push;
	assign pop        = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= M_IDLE;
			nm_q     <= NM_ZERO;
			ft_q     <= TT_STRING;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (byte_ready)
				valid_s1 <= byte_valid;
			if (push) begin
				mode_q   <= mode_d;
				nm_q     <= nm_d;
				ft_q     <= ft_d;
				wr_ptr_q <= wr_ptr_q + PTR_W'(n);
			end
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			count_q <= count_q + (push ? CNT_W'(n) : CNT_W'(0)) - (pop ? CNT_W'(1) : CNT_W'(0));
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			byte_s1 <= in_byte;
			eol_s1  <= end_of_line;
		end
		if (push) begin
			for (int i = 0; i < MAX_RES; i++) begin
				if (2'(i) < n)
					mem_q[wr_ptr_q + PTR_W'(i)] <= res[i];
			end
		end
	end

	assign result_valid = (count_q != '0);
	assign has_char     = mem_q[rd_ptr_q].has_char;
	assign token_char   = mem_q[rd_ptr_q].token_char;
	assign token_end    = mem_q[rd_ptr_q].token_end;
	assign token_type   = mem_q[rd_ptr_q].token_type;
	assign line_done    = mem_q[rd_ptr_q].line_done;
	assign run_last     = mem_q[rd_ptr_q].run_last;

endmodule

>>> rtl/ntl_checker.sv
// ----------------------------------------------------------------------------
// ntl_checker
// Port-level checks on the result stream of the netlist lexer.
// ----------------------------------------------------------------------------
module ntl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_ready,
	input logic       has_char,
	input logic [7:0] token_char,
	input logic       token_end,
	input logic [2:0] token_type,
	input logic       line_done,
	input logic       run_last
);
	import ntl_pkg::*;

	// type only travels on end markers
	a_type_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !token_end |-> token_type == TT_STRING)
		else $error("token type set without end marker");

	// line done is bare and always closes its byte's group
	a_line_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && line_done |-> run_last && !has_char && !token_end)
		else $error("malformed line done result");

	// end marker without a character carries a zero character
	a_bare_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && token_end && !has_char |-> token_char == CH_NUL)
		else $error("bare end marker carries a character");

	// stalled result stays valid and holds its character, end and run-last fields
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(token_char) &&
			$stable(has_char) && $stable(token_end) && $stable(run_last))
		else $error("stalled result changed");

endmodule

bind netlist_token_lexer ntl_checker u_ntl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.has_char     (has_char),
	.token_char   (token_char),
	.token_end    (token_end),
	.token_type   (token_type),
	.line_done    (line_done),
	.run_last     (run_last)
);

>>> dv/netlist_token_lexer_test.sv
// ----------------------------------------------------------------------------
// netlist_token_lexer_test
// Streams text lines into the lexer one byte per request. This starts with a
// short directed set of separators, one-character tokens, quoting, "null",
// high bytes and line ends, then moves on to randomly built lines. A
// scoreboard predicts the token characters, end markers and line-done
// results and checks every returned result in order. Both channels stall at
// random.
// ----------------------------------------------------------------------------
module netlist_token_lexer_test;
	import ntl_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int STREAM_BYTES = 380;

	typedef enum logic [1:0] {LX_IDLE, LX_WORD, LX_QOPEN, LX_QTEXT} lex_state_t;

	class token_scoreboard;
		lex_state_t state;
		logic [2:0] null_seen;
		logic [2:0] lead_type;
		res_t       due_results[$];
		int         errors;

		function new();
			state     = LX_IDLE;
			null_seen = NM_ZERO;
			lead_type = TT_STRING;
			errors    = 0;
		endfunction

		function logic splits(logic [7:0] c);
			return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
				c == CH_FF || c == CH_CR || c == CH_EQ || c == CH_LPAR ||
				c == CH_RPAR || c == CH_COMMA;
		endfunction

		function logic [2:0] lone_kind(logic [7:0] c);
			case (c)
				CH_LBRK:  return TT_LBRK;
				CH_RBRK:  return TT_RBRK;
				CH_LT:    return TT_LT;
				CH_GT:    return TT_GT;
				CH_PCT:   return TT_PCT;
				CH_TILDE: return TT_TILDE;
				default:  return TT_STRING;
			endcase
		endfunction

		function void push(logic hc, logic [7:0] ch, logic te, logic [2:0] ty, logic ld);
			res_t r;
			r.has_char   = hc;
			r.token_char = ch;
			r.token_end  = te;
			r.token_type = ty;
			r.line_done  = ld;
			r.run_last   = 1'b0;
			due_results.push_back(r);
		endfunction

		function void follow_null(logic [7:0] c);
			logic [7:0] want;
			case (null_seen)
				3'd0:    want = CH_N;
				3'd1:    want = CH_U;
				default: want = CH_L;
			endcase
			if (null_seen < NM_FULL && c == want)
				null_seen = null_seen + 3'd1;
			else
				null_seen = NM_FAIL;
		endfunction

		function void close_token();
			logic [2:0] ty;
			ty = TT_STRING;
			if (state == LX_QTEXT && lead_type != TT_STRING)
				ty = lead_type;
			else if (null_seen == NM_FULL)
				ty = TT_NULL;
			push(1'b0, 8'h00, 1'b1, ty, 1'b0);
			state     = LX_IDLE;
			null_seen = NM_ZERO;
			lead_type = TT_STRING;
		endfunction

		function void take_byte(logic [7:0] c, logic eol);
			logic [2:0] kind;
			int         base;
			res_t       r;
			base = due_results.size();
			kind = lone_kind(c);
			if (c != CH_NUL) begin
				case (state)
					LX_IDLE: begin
						if (kind != TT_STRING) begin
							push(1'b1, c, 1'b1, kind, 1'b0);
						end else if (c == CH_QUOTE) begin
							state     = LX_QOPEN;
							null_seen = NM_ZERO;
							lead_type = TT_STRING;
						end else if (!splits(c)) begin
							state     = LX_WORD;
							null_seen = NM_ZERO;
							lead_type = TT_STRING;
							follow_null(c);
							push(1'b1, c, 1'b0, TT_STRING, 1'b0);
						end
					end
					LX_WORD: begin
						if (splits(c)) begin
							close_token();
						end else if (kind != TT_STRING) begin
							close_token();
							push(1'b1, c, 1'b1, kind, 1'b0);
						end else begin
							follow_null(c);
							push(1'b1, c, 1'b0, TT_STRING, 1'b0);
						end
					end
					default: begin
						if (c == CH_QUOTE) begin
							close_token();
						end else begin
							if (state == LX_QOPEN) begin
								lead_type = kind;
								state     = LX_QTEXT;
							end
							follow_null(c);
							push(1'b1, c, 1'b0, TT_STRING, 1'b0);
						end
					end
				endcase
			end
			if (eol || c == CH_NUL) begin
				if (state != LX_IDLE)
					close_token();
				push(1'b0, 8'h00, 1'b0, TT_STRING, 1'b1);
				state     = LX_IDLE;
				null_seen = NM_ZERO;
				lead_type = TT_STRING;
			end
			if (due_results.size() > base) begin
				r = due_results.pop_back();
				r.run_last = 1'b1;
				due_results.push_back(r);
			end
		endfunction

		function void check_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %p", $time, got);
				errors++;
				return;
			end
			want = due_results.pop_front();
			check_field("has_char", 8'(want.has_char), 8'(got.has_char));
			check_field("token_char", want.token_char, got.token_char);
			check_field("token_end", 8'(want.token_end), 8'(got.token_end));
			check_field("token_type", 8'(want.token_type), 8'(got.token_type));
			check_field("line_done", 8'(want.line_done), 8'(got.line_done));
			check_field("run_last", 8'(want.run_last), 8'(got.run_last));
		endfunction

		function int outstanding();
			return due_results.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n       = 1'b0;
	logic       byte_valid   = 1'b0;
	logic       byte_ready;
	logic [7:0] in_byte      = 8'h00;
	logic       end_of_line  = 1'b0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	logic       has_char;
	logic [7:0] token_char;
	logic       token_end;
	logic [2:0] token_type;
	logic       line_done;
	logic       run_last;

	token_scoreboard scoreboard;
	res_t            seen;
	int              cycles      = 0;
	int              random_sent = 0;
	bit              calm        = 1'b0;
	logic [7:0]      line_bytes[$];

	netlist_token_lexer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.in_byte      (in_byte),
		.end_of_line  (end_of_line),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.has_char     (has_char),
		.token_char   (token_char),
		.token_end    (token_end),
		.token_type   (token_type),
		.line_done    (line_done),
		.run_last     (run_last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles = cycles + 1;
		if (arst_n) begin
			if (byte_valid && byte_ready)
				scoreboard.take_byte(in_byte, end_of_line);
			if (result_valid && result_ready) begin
				seen = {has_char, token_char, token_end, token_type, line_done, run_last};
				scoreboard.check_result(seen);
			end
		end
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int pick_gap();
		int p;
		if (calm)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 88)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// result side back-pressure
	initial begin
		int run;
		int stall;
		@(posedge arst_n);
		forever begin
			run = $urandom_range(1, 20);
			result_ready <= 1'b1;
			repeat (run) @(posedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eol);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid  <= 1'b1;
		in_byte     <= b;
		end_of_line <= eol;
		do @(posedge clk); while (!byte_ready);
	endtask

	task automatic send_text(input string s, input logic eol);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], eol && i == s.len() - 1);
	endtask

	function automatic logic [7:0] word_char();
		int p;
		p = $urandom_range(0, 9);
		if (p < 8)
			return 8'h61 + 8'($urandom_range(0, 25));
		if (p < 9)
			return 8'h30 + 8'($urandom_range(0, 9));
		return 8'($urandom_range(128, 255));
	endfunction

	function automatic logic [7:0] sep_char();
		case ($urandom_range(0, 9))
			0:       return CH_TAB;
			1:       return CH_LF;
			2:       return CH_VT;
			3:       return CH_FF;
			4:       return CH_CR;
			5:       return CH_EQ;
			6:       return CH_LPAR;
			7:       return CH_RPAR;
			8:       return CH_COMMA;
			default: return CH_SPACE;
		endcase
	endfunction

	function automatic logic [7:0] lone_char();
		case ($urandom_range(0, 5))
			0:       return CH_LBRK;
			1:       return CH_RBRK;
			2:       return CH_LT;
			3:       return CH_GT;
			4:       return CH_PCT;
			default: return CH_TILDE;
		endcase
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_bytes.push_back(s[i]);
	endfunction

	function automatic void add_null_like();
		case ($urandom_range(0, 4))
			0, 1:    add_text("null");
			2:       add_text("nul");
			3:       add_text("nulls");
			default: add_text("nuLl");
		endcase
	endfunction

	// mostly well-formed tokens, with some raw noise
	function automatic void build_line();
		int tokens;
		int p;
		int len;
		line_bytes.delete();
		tokens = $urandom_range(1, 6);
		for (int t = 0; t < tokens; t++) begin
			p = $urandom_range(0, 99);
			if (p < 35) begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++)
					line_bytes.push_back(word_char());
			end else if (p < 45) begin
				add_null_like();
			end else if (p < 65) begin
				line_bytes.push_back(CH_QUOTE);
				if ($urandom_range(0, 4) == 0) begin
					add_null_like();
				end else begin
					len = $urandom_range(0, 5);
					for (int i = 0; i < len; i++) begin
						case ($urandom_range(0, 9))
							0, 1:    line_bytes.push_back(lone_char());
							2:       line_bytes.push_back(sep_char());
							default: line_bytes.push_back(word_char());
						endcase
					end
				end
				if ($urandom_range(0, 4) != 0)
					line_bytes.push_back(CH_QUOTE);
			end else if (p < 85) begin
				line_bytes.push_back(lone_char());
			end else begin
				line_bytes.push_back(8'($urandom_range(1, 255)));
			end
			if ($urandom_range(0, 3) != 0)
				line_bytes.push_back(sep_char());
		end
	endfunction

	task automatic send_line();
		int   ending;
		logic last_flag;
		ending    = $urandom_range(0, 99);
		last_flag = 1'b1;
		if (ending >= 65 && ending < 80) begin
			line_bytes.push_back(CH_NUL);
			last_flag = 1'($urandom_range(0, 1));
		end else if (ending >= 80 && ending < 90) begin
			line_bytes.push_back(sep_char());
		end else if (ending >= 90) begin
			line_bytes.push_back(8'($urandom_range(0, 255)));
		end
		for (int i = 0; i < line_bytes.size(); i++) begin
			send_byte(line_bytes[i], i == line_bytes.size() - 1 ? last_flag : 1'b0);
			random_sent++;
		end
	endtask

	initial begin
		scoreboard = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: words closed by a lone token, "null", quoted forms
		send_text("[ab]", 1'b0);
		send_text(" null,", 1'b0);
		send_text("\"<x\"\"\"", 1'b0);
		send_text("%~>", 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(CH_NUL, 1'b1);
		send_text("\"null", 1'b1);

		while (random_sent < STREAM_BYTES) begin
			calm = ($urandom_range(0, 7) == 0);
			build_line();
			send_line();
		end
		byte_valid <= 1'b0;

		while (scoreboard.outstanding() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (scoreboard.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> sim.f
rtl/ntl_pkg.sv
rtl/netlist_token_lexer.sv
rtl/ntl_checker.sv
dv/netlist_token_lexer_test.sv
